### hw/rtl/ufc_pkg.sv
// Shared types and constants for the union-find components engine.
`timescale 1ns / 1ps

package ufc_pkg;

   localparam int VERTICES = 1024;
   localparam int VTX_W    = $clog2(VERTICES);
   localparam int LABEL_W  = 11;
   localparam int PAR_W    = 12;
   localparam int CNT_W    = 11;
   localparam int WORD_W   = PAR_W + 1;

   localparam logic [1:0] OP_UNION = 2'd0;
   localparam logic [1:0] OP_FIND  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_U_RDA,
      S_U_MKA,
      S_U_RDB,
      S_U_MKB,
      S_U_RDI,
      S_U_WI,
      S_U_RDJ,
      S_U_WJ,
      S_U_RCI,
      S_U_CI,
      S_U_RCJ,
      S_U_CJ,
      S_U_LK1,
      S_U_LK2,
      S_F_RD,
      S_F_CHK,
      S_F_WALK,
      S_F_FIX,
      S_RESP
   } state_type;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LOAD,
      UOP_CLEAR,
      UOP_RD_LO,
      UOP_RD_HI,
      UOP_MARK,
      UOP_WALK_I,
      UOP_WALK_J,
      UOP_COMP_I,
      UOP_COMP_J,
      UOP_LINK1,
      UOP_LINK2,
      UOP_FIX,
      UOP_OUT
   } uop_type;

   typedef struct packed {
      uop_type uop;
   } cmd_type;

   typedef struct packed {
      logic rd_pos;
      logic rd_seen;
      logic same_vtx;
      logic same_root;
      logic clr_last;
   } sts_type;

endpackage

### hw/rtl/ufc_dpath.sv
// Datapath: parent/seen memory, walk pointers, root registers, count and result beat.
`timescale 1ns / 1ps

module ufc_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  ufc_pkg::cmd_type          cmd,
   output ufc_pkg::sts_type          sts,
   input  logic [1:0]                req_op,
   input  logic [ufc_pkg::VTX_W-1:0] req_vertex_a,
   input  logic [ufc_pkg::VTX_W-1:0] req_vertex_b,
   output logic                      rsp_merged,
   output logic [ufc_pkg::LABEL_W-1:0] rsp_component,
   output logic [ufc_pkg::CNT_W-1:0] rsp_node_count
);
   import ufc_pkg::*;

   // word = {seen, parent}; parent > 0 links to a label, <= 0 marks a root
   logic [WORD_W-1:0] mem [VERTICES];
   logic [WORD_W-1:0] rd_ff;

   logic [VTX_W-1:0] lo_ff, lo_in, hi_ff, hi_in, cur_ff, cur_in;
   logic [VTX_W-1:0] i_ff, i_in, j_ff, j_in, clr_ff, clr_in;
   logic signed [PAR_W-1:0] vi_ff, vi_in, vj_ff, vj_in;
   logic si_ff, si_in, sj_ff, sj_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic merged_ff, merged_in;
   logic [LABEL_W-1:0] comp_ff, comp_in;
   logic out_merged_ff, out_merged_in;
   logic [LABEL_W-1:0] out_comp_ff, out_comp_in;
   logic [CNT_W-1:0] out_cnt_ff, out_cnt_in;

   logic rd_en, wr_en;
   logic [VTX_W-1:0] rd_addr, wr_addr;
   logic [WORD_W-1:0] wr_data;

   logic rd_seen, rd_pos, j_wins;
   logic signed [PAR_W-1:0] rd_par, par_sum;
   logic [PAR_W-1:0] rd_dec, lbl_i, lbl_j;
   logic [VTX_W-1:0] rd_next;

   assign rd_seen = rd_ff[WORD_W-1];
   assign rd_par  = signed'(rd_ff[PAR_W-1:0]);
   assign rd_pos  = !rd_par[PAR_W-1] && (rd_par != '0);
   assign rd_dec  = rd_ff[PAR_W-1:0] - PAR_W'(1);
   assign rd_next = rd_dec[VTX_W-1:0];
   assign lbl_i   = PAR_W'(i_ff) + PAR_W'(1);
   assign lbl_j   = PAR_W'(j_ff) + PAR_W'(1);
   assign j_wins  = vj_ff < vi_ff;
   assign par_sum = vi_ff + vj_ff - PAR_W'(1);

   assign sts.rd_pos    = rd_pos;
   assign sts.rd_seen   = rd_seen;
   assign sts.same_vtx  = lo_ff == hi_ff;
   assign sts.same_root = i_ff == j_ff;
   assign sts.clr_last  = clr_ff == VTX_W'(VERTICES - 1);

   assign rsp_merged     = out_merged_ff;
   assign rsp_component  = out_comp_ff;
   assign rsp_node_count = out_cnt_ff;

   always_comb begin
      rd_en = 1'b0;
      rd_addr = cur_ff;
      wr_en = 1'b0;
      wr_addr = cur_ff;
      wr_data = '0;
      lo_in = lo_ff;
      hi_in = hi_ff;
      cur_in = cur_ff;
      i_in = i_ff;
      j_in = j_ff;
      vi_in = vi_ff;
      vj_in = vj_ff;
      si_in = si_ff;
      sj_in = sj_ff;
      clr_in = clr_ff;
      cnt_in = cnt_ff;
      merged_in = merged_ff;
      comp_in = comp_ff;
      out_merged_in = out_merged_ff;
      out_comp_in = out_comp_ff;
      out_cnt_in = out_cnt_ff;
      case (cmd.uop)
         UOP_LOAD: begin
            if (req_op == OP_UNION && req_vertex_b < req_vertex_a) begin
               lo_in = req_vertex_b;
               hi_in = req_vertex_a;
            end else begin
               lo_in = req_vertex_a;
               hi_in = req_vertex_b;
            end
            merged_in = 1'b0;
            comp_in = '0;
         end
         UOP_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + VTX_W'(1);
            cnt_in = '0;
         end
         UOP_RD_LO: begin
            rd_en = 1'b1;
            rd_addr = lo_ff;
            cur_in = lo_ff;
         end
         UOP_RD_HI: begin
            rd_en = 1'b1;
            rd_addr = hi_ff;
            cur_in = hi_ff;
         end
         UOP_MARK: begin
            if (!rd_seen) begin
               wr_en = 1'b1;
               wr_data = {1'b1, rd_ff[PAR_W-1:0]};
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         UOP_WALK_I: begin
            if (rd_pos) begin
               rd_en = 1'b1;
               rd_addr = rd_next;
               cur_in = rd_next;
            end else begin
               i_in = cur_ff;
               vi_in = rd_par;
               si_in = rd_seen;
            end
         end
         UOP_WALK_J: begin
            if (rd_pos) begin
               rd_en = 1'b1;
               rd_addr = rd_next;
               cur_in = rd_next;
            end else begin
               j_in = cur_ff;
               vj_in = rd_par;
               sj_in = rd_seen;
            end
         end
         UOP_COMP_I: begin
            if (rd_pos) begin
               wr_en = 1'b1;
               wr_data = {rd_seen, lbl_i};
               rd_en = 1'b1;
               rd_addr = rd_next;
               cur_in = rd_next;
            end
         end
         UOP_COMP_J: begin
            if (rd_pos) begin
               wr_en = 1'b1;
               wr_data = {rd_seen, lbl_j};
               rd_en = 1'b1;
               rd_addr = rd_next;
               cur_in = rd_next;
            end
         end
         UOP_LINK1: begin
            wr_en = 1'b1;
            if (j_wins) begin
               wr_addr = i_ff;
               wr_data = {si_ff, lbl_j};
            end else begin
               wr_addr = j_ff;
               wr_data = {sj_ff, lbl_i};
            end
         end
         UOP_LINK2: begin
            wr_en = 1'b1;
            merged_in = 1'b1;
            if (j_wins) begin
               wr_addr = j_ff;
               wr_data = {sj_ff, par_sum};
            end else begin
               wr_addr = i_ff;
               wr_data = {si_ff, par_sum};
            end
         end
         UOP_FIX: begin
            comp_in = LABEL_W'(i_ff) + LABEL_W'(1);
            if (i_ff != lo_ff) begin
               wr_en = 1'b1;
               wr_addr = lo_ff;
               wr_data = {1'b1, lbl_i};
            end
         end
         UOP_OUT: begin
            out_merged_in = merged_ff;
            out_comp_in = comp_ff;
            out_cnt_in = cnt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      cur_ff <= cur_in;
      i_ff <= i_in;
      j_ff <= j_in;
      vi_ff <= vi_in;
      vj_ff <= vj_in;
      si_ff <= si_in;
      sj_ff <= sj_in;
      merged_ff <= merged_in;
      comp_ff <= comp_in;
      out_merged_ff <= out_merged_in;
      out_comp_ff <= out_comp_in;
      out_cnt_ff <= out_cnt_in;
   end

endmodule

### hw/rtl/ufc_ctrl.sv
// Controller: sequences union, find and clear over the datapath; owns the handshakes.
`timescale 1ns / 1ps

module ufc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_op,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ufc_pkg::cmd_type cmd,
   input  ufc_pkg::sts_type sts
);
   import ufc_pkg::*;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.uop = UOP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_INIT: begin
            cmd.uop = UOP_CLEAR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.uop = UOP_LOAD;
               case (req_op)
                  OP_UNION: state_in = S_U_RDA;
                  OP_FIND:  state_in = S_F_RD;
                  OP_CLEAR: state_in = S_CLEAR;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.uop = UOP_CLEAR;
            if (sts.clr_last) state_in = S_RESP;
         end
         S_U_RDA: begin
            cmd.uop = UOP_RD_LO;
            state_in = S_U_MKA;
         end
         S_U_MKA: begin
            cmd.uop = UOP_MARK;
            state_in = S_U_RDB;
         end
         S_U_RDB: begin
            cmd.uop = UOP_RD_HI;
            state_in = S_U_MKB;
         end
         S_U_MKB: begin
            cmd.uop = UOP_MARK;
            state_in = sts.same_vtx ? S_RESP : S_U_RDI;
         end
         S_U_RDI: begin
            cmd.uop = UOP_RD_LO;
            state_in = S_U_WI;
         end
         S_U_WI: begin
            cmd.uop = UOP_WALK_I;
            if (!sts.rd_pos) state_in = S_U_RDJ;
         end
         S_U_RDJ: begin
            cmd.uop = UOP_RD_HI;
            state_in = S_U_WJ;
         end
         S_U_WJ: begin
            cmd.uop = UOP_WALK_J;
            if (!sts.rd_pos) state_in = S_U_RCI;
         end
         S_U_RCI: begin
            cmd.uop = UOP_RD_LO;
            state_in = S_U_CI;
         end
         S_U_CI: begin
            cmd.uop = UOP_COMP_I;
            if (!sts.rd_pos) state_in = S_U_RCJ;
         end
         S_U_RCJ: begin
            cmd.uop = UOP_RD_HI;
            state_in = S_U_CJ;
         end
         S_U_CJ: begin
            cmd.uop = UOP_COMP_J;
            if (!sts.rd_pos) state_in = sts.same_root ? S_RESP : S_U_LK1;
         end
         S_U_LK1: begin
            cmd.uop = UOP_LINK1;
            state_in = S_U_LK2;
         end
         S_U_LK2: begin
            cmd.uop = UOP_LINK2;
            state_in = S_RESP;
         end
         S_F_RD: begin
            cmd.uop = UOP_RD_LO;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (!sts.rd_seen) begin
               state_in = S_RESP;
            end else begin
               cmd.uop = UOP_WALK_I;
               state_in = sts.rd_pos ? S_F_WALK : S_F_FIX;
            end
         end
         S_F_WALK: begin
            cmd.uop = UOP_WALK_I;
            if (!sts.rd_pos) state_in = S_F_FIX;
         end
         S_F_FIX: begin
            cmd.uop = UOP_FIX;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.uop = UOP_OUT;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/union_find_components_core.sv
// Top level of the union-find components engine: controller plus datapath.
//
//  channel | ports                                         | role
//  req     | req_valid req_stall req_op req_vertex_a/_b    | op beat in
//  rsp     | rsp_valid rsp_stall rsp_merged rsp_component  | result beat out
//          | rsp_node_count                                |
//
// One op at a time; the table has a single read port. After reset a clearing pass
// wipes it with req_stall high meanwhile, as Clear does. Union marks both vertices;
// for distinct ones it walks and compresses both paths and links the roots if the
// sets differ. Find returns 0 for an unseen vertex, else walks to the root and points the vertex at it.
// A waiting result beat does not block the next op; only its own delivery waits.
`timescale 1ns / 1ps

module union_find_components_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_op,
   input  logic [ufc_pkg::VTX_W-1:0]   req_vertex_a,
   input  logic [ufc_pkg::VTX_W-1:0]   req_vertex_b,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_merged,
   output logic [ufc_pkg::LABEL_W-1:0] rsp_component,
   output logic [ufc_pkg::CNT_W-1:0]   rsp_node_count
);
   import ufc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ufc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ufc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .rsp_merged     (rsp_merged),
      .rsp_component  (rsp_component),
      .rsp_node_count (rsp_node_count)
   );

endmodule

### verif/tb_union_find_components_core.sv
// Self-checking testbench for the union-find components engine.
`timescale 1ns / 1ps

module tb_union_find_components_core;
   import ufc_pkg::*;

   typedef struct {
      logic                merged;
      logic [LABEL_W-1:0]  component;
      logic [CNT_W-1:0]    node_count;
   } uf_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic [VTX_W-1:0]   req_vertex_a;
   logic [VTX_W-1:0]   req_vertex_b;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_merged;
   logic [LABEL_W-1:0] rsp_component;
   logic [CNT_W-1:0]   rsp_node_count;

   // predictor state
   int            forest[VERTICES+1];
   bit            seen_vtx[VERTICES];
   int            seen_total;
   uf_result_type pending_results[$];
   int            fail_count;
   int            send_idle_pct;
   int            stall_pct;

   union_find_components_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("simulation failed");
      $finish;
   end

   function automatic int walk_root(int lbl);
      int r;
      int g;
      r = lbl;
      g = 0;
      while (forest[r] > 0 && g <= VERTICES) begin
         r = forest[r];
         g++;
      end
      return r;
   endfunction

   function automatic void flatten(int lbl, int root);
      int x;
      int nxt;
      int g;
      x = lbl;
      g = 0;
      while (forest[x] > 0 && g <= VERTICES) begin
         nxt = forest[x];
         forest[x] = root;
         x = nxt;
         g++;
      end
   endfunction

   function automatic void wipe_forest();
      foreach (forest[i]) forest[i] = 0;
      foreach (seen_vtx[i]) seen_vtx[i] = 0;
      seen_total = 0;
   endfunction

   function automatic void note_seen(int v);
      if (!seen_vtx[v]) begin
         seen_vtx[v] = 1;
         seen_total++;
      end
   endfunction

   function automatic uf_result_type predict_components(logic [1:0] op, int a, int b);
      uf_result_type res;
      int lo, hi, i, j, r;
      res.merged = 0;
      res.component = '0;
      if (op == OP_UNION) begin
         note_seen(a);
         note_seen(b);
         if (a != b) begin
            lo = (a < b ? a : b) + 1;
            hi = (a < b ? b : a) + 1;
            i = walk_root(lo);
            j = walk_root(hi);
            flatten(lo, i);
            flatten(hi, j);
            if (i != j) begin
               res.merged = 1;
               if (forest[j] < forest[i]) begin
                  forest[j] += forest[i] - 1;
                  forest[i] = j;
               end else begin
                  forest[i] += forest[j] - 1;
                  forest[j] = i;
               end
            end
         end
      end else if (op == OP_FIND) begin
         if (seen_vtx[a]) begin
            r = walk_root(a + 1);
            if (r != a + 1) forest[a + 1] = r;
            res.component = LABEL_W'(r);
         end
      end else if (op == OP_CLEAR) begin
         wipe_forest();
      end
      res.node_count = CNT_W'(seen_total);
      return res;
   endfunction

   task automatic send_op(logic [1:0] op, int a, int b);
      logic [VTX_W-1:0] va;
      logic [VTX_W-1:0] vb;
      va = a[VTX_W-1:0];
      vb = b[VTX_W-1:0];
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_vertex_a <= va;
      req_vertex_b <= vb;
      do @(posedge clock); while (req_stall);
      pending_results = {pending_results, predict_components(op, int'(va), int'(vb))};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat");
            end else begin
               uf_result_type e;
               e = pending_results.pop_front();
               if (e.merged !== rsp_merged || e.component !== rsp_component ||
                   e.node_count !== rsp_node_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                              e.merged, e.component, e.node_count,
                              rsp_merged, rsp_component, rsp_node_count);
               end
            end
         end
         rsp_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
   end

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(OP_FIND, 0, 0);
      send_op(OP_UNION, 0, 1023);
      send_op(OP_UNION, 5, 5);
      send_op(OP_UNION, 2, 3);
      send_op(OP_UNION, 3, 2);
      send_op(OP_UNION, 1023, 3);
      send_op(OP_FIND, 1023, 0);
      send_op(OP_FIND, 2, 0);
      send_op(OP_FIND, 4, 0);
      send_op(OP_SPARE, 1023, 1023);
      send_op(OP_UNION, 512, 511);
      send_op(OP_UNION, 341, 682);
      send_op(OP_FIND, 682, 0);
      send_op(OP_CLEAR, 1023, 1023);
      send_op(OP_FIND, 0, 0);
      send_op(OP_UNION, 1, 2);
      send_op(OP_FIND, 2, 0);
   endtask

   task automatic test_random(int n);
      int k;
      for (k = 0; k < n; k++) begin
         int r;
         r = $urandom_range(99);
         if (r < 60) send_op(OP_UNION, $urandom_range(63), $urandom_range(63));
         else if (r < 92) send_op(OP_FIND, $urandom_range(63), $urandom);
         else if (r < 95) send_op(OP_UNION, $urandom, $urandom);
         else if (r < 98) send_op(OP_SPARE, $urandom, $urandom);
         else send_op(OP_CLEAR, $urandom, $urandom);
      end
   endtask

   task automatic test_quiesce();
      drain();
      send_op(OP_FIND, $urandom_range(63), 0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = '0;
      req_vertex_a = '0;
      req_vertex_b = '0;
      fail_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      wipe_forest();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(130);
      send_idle_pct = 49;
      test_random(130);
      test_quiesce();
      send_idle_pct = 0;
      stall_pct = 49;
      test_random(130);
      send_idle_pct = 22;
      stall_pct = 22;
      test_random(130);
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

### filelist.f
hw/rtl/ufc_pkg.sv
hw/rtl/ufc_dpath.sv
hw/rtl/ufc_ctrl.sv
hw/rtl/union_find_components_core.sv
verif/tb_union_find_components_core.sv
